### design/rdr_pkg.sv
// Shared constants for the ray differential reflection pipeline.
package rdr_pkg;

    // Default component width: signed Q3.12
    localparam int COMP_WIDTH_DEF = 16;
    // Components per packed vector (x, y, z)
    localparam int N_COMP = 3;
    // Integer bits of a component, sign included; fraction bits = width - this
    localparam int INT_BITS = 4;
    // Growth of a rounded dot product over the component width
    localparam int DOT_GROW = 7;

endpackage

### design/ray_differential_reflect.sv
// Throughput: one transaction per cycle while the output is not stalled; four
// register stages (products, dot rounding, scaled products, combine and
// saturate) advance together and carry each transaction to the outputs.
// A stall on the output freezes all stages while the last one holds a result.
// Reset (synchronous, active low) clears the stage valid bits; data is not reset.
// Top level of the ray differential reflection pipeline.
module ray_differential_reflect
    import rdr_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [N_COMP*COMP_WIDTH-1:0] i_ray_dir,
    input  logic [N_COMP*COMP_WIDTH-1:0] i_surf_normal,
    input  logic [N_COMP*COMP_WIDTH-1:0] i_normal_du,
    input  logic [N_COMP*COMP_WIDTH-1:0] i_normal_dv,
    input  logic [N_COMP*COMP_WIDTH-1:0] i_dir_dx,
    input  logic [N_COMP*COMP_WIDTH-1:0] i_dir_dy,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [N_COMP*COMP_WIDTH-1:0] o_refl_dir,
    output logic [N_COMP*COMP_WIDTH-1:0] o_refl_dir_dx,
    output logic [N_COMP*COMP_WIDTH-1:0] o_refl_dir_dy
);

    localparam int VW = N_COMP * COMP_WIDTH;
    localparam int DW = COMP_WIDTH + DOT_GROW;
    localparam int NSTG = 4;

    logic            en;
    logic [NSTG-1:0] r_vld;

    logic [VW-1:0] r_dir1, r_nrm1, r_ndu1, r_ndv1, r_ddx1, r_ddy1;
    logic [VW-1:0] r_dir2, r_nrm2, r_ndu2, r_ndv2, r_ddx2, r_ddy2;

    logic signed [DW-1:0] p;
    logic signed [DW-1:0] qx;
    logic signed [DW-1:0] qy;

    // Advance every stage unless a finished result waits on a stalled output
    assign en      = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NSTG-1];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // Delay the input vectors to line up with the rounded dot products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dir1 <= i_ray_dir;
            r_nrm1 <= i_surf_normal;
            r_ndu1 <= i_normal_du;
            r_ndv1 <= i_normal_dv;
            r_ddx1 <= i_dir_dx;
            r_ddy1 <= i_dir_dy;
            r_dir2 <= r_dir1;
            r_nrm2 <= r_nrm1;
            r_ndu2 <= r_ndu1;
            r_ndv2 <= r_ndv1;
            r_ddx2 <= r_ddx1;
            r_ddy2 <= r_ddy1;
        end
    end

    rdr_dot_unit #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_dot (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_ray_dir     (i_ray_dir),
        .i_surf_normal (i_surf_normal),
        .i_normal_du   (i_normal_du),
        .i_normal_dv   (i_normal_dv),
        .i_dir_dx      (i_dir_dx),
        .i_dir_dy      (i_dir_dy),
        .o_p           (p),
        .o_qx          (qx),
        .o_qy          (qy)
    );

    // Mirror direction: d - 2 (d.n) n
    rdr_reflect_lane #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_lane_dir (
        .i_clk (i_clk),
        .i_en  (en),
        .i_dd  (r_dir2),
        .i_dn  ({VW{1'b0}}),
        .i_nrm (r_nrm2),
        .i_p   ({DW{1'b0}}),
        .i_q   (p),
        .o_res (o_refl_dir)
    );

    // Reflected x differential
    rdr_reflect_lane #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_lane_dx (
        .i_clk (i_clk),
        .i_en  (en),
        .i_dd  (r_ddx2),
        .i_dn  (r_ndu2),
        .i_nrm (r_nrm2),
        .i_p   (p),
        .i_q   (qx),
        .o_res (o_refl_dir_dx)
    );

    // Reflected y differential
    rdr_reflect_lane #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_lane_dy (
        .i_clk (i_clk),
        .i_en  (en),
        .i_dd  (r_ddy2),
        .i_dn  (r_ndv2),
        .i_nrm (r_nrm2),
        .i_p   (p),
        .i_q   (qy),
        .o_res (o_refl_dir_dy)
    );

endmodule

### design/rdr_dot_unit.sv
// Two-stage dot product unit: d.n, dD.n + d.dN for x and y, rounded.
module rdr_dot_unit
    import rdr_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [N_COMP*COMP_WIDTH-1:0]           i_ray_dir,
    input  logic [N_COMP*COMP_WIDTH-1:0]           i_surf_normal,
    input  logic [N_COMP*COMP_WIDTH-1:0]           i_normal_du,
    input  logic [N_COMP*COMP_WIDTH-1:0]           i_normal_dv,
    input  logic [N_COMP*COMP_WIDTH-1:0]           i_dir_dx,
    input  logic [N_COMP*COMP_WIDTH-1:0]           i_dir_dy,
    output logic signed [COMP_WIDTH+DOT_GROW-1:0]  o_p,
    output logic signed [COMP_WIDTH+DOT_GROW-1:0]  o_qx,
    output logic signed [COMP_WIDTH+DOT_GROW-1:0]  o_qy
);

    localparam int W  = COMP_WIDTH;
    localparam int F  = COMP_WIDTH - INT_BITS;
    localparam int PW = 2 * W;
    localparam int AW = 2 * W + 3;
    localparam int DW = W + DOT_GROW;
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (F - 1);

    logic signed [W-1:0]  d   [N_COMP];
    logic signed [W-1:0]  nv  [N_COMP];
    logic signed [W-1:0]  ndu [N_COMP];
    logic signed [W-1:0]  ndv [N_COMP];
    logic signed [W-1:0]  ddx [N_COMP];
    logic signed [W-1:0]  ddy [N_COMP];

    logic signed [PW-1:0] r_pn [N_COMP];
    logic signed [PW-1:0] r_xn [N_COMP];
    logic signed [PW-1:0] r_xd [N_COMP];
    logic signed [PW-1:0] r_yn [N_COMP];
    logic signed [PW-1:0] r_yd [N_COMP];

    logic signed [AW-1:0] s_p;
    logic signed [AW-1:0] s_qx;
    logic signed [AW-1:0] s_qy;
    logic signed [DW-1:0] n_p;
    logic signed [DW-1:0] n_qx;
    logic signed [DW-1:0] n_qy;

    // Unpack components, x in the top bits
    always_comb begin
        for (int i = 0; i < N_COMP; i++) begin
            d[i]   = $signed(i_ray_dir[(N_COMP-1-i)*W +: W]);
            nv[i]  = $signed(i_surf_normal[(N_COMP-1-i)*W +: W]);
            ndu[i] = $signed(i_normal_du[(N_COMP-1-i)*W +: W]);
            ndv[i] = $signed(i_normal_dv[(N_COMP-1-i)*W +: W]);
            ddx[i] = $signed(i_dir_dx[(N_COMP-1-i)*W +: W]);
            ddy[i] = $signed(i_dir_dy[(N_COMP-1-i)*W +: W]);
        end
    end

    // Stage 1: register all component products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N_COMP; i++) begin
                r_pn[i] <= d[i] * nv[i];
                r_xn[i] <= ddx[i] * nv[i];
                r_xd[i] <= d[i] * ndu[i];
                r_yn[i] <= ddy[i] * nv[i];
                r_yd[i] <= d[i] * ndv[i];
            end
        end
    end

    // Sum products exactly, then round half up to the component fraction
    always_comb begin
        s_p  = HALF;
        s_qx = HALF;
        s_qy = HALF;
        for (int i = 0; i < N_COMP; i++) begin
            s_p  = s_p  + AW'(r_pn[i]);
            s_qx = s_qx + AW'(r_xn[i]) + AW'(r_xd[i]);
            s_qy = s_qy + AW'(r_yn[i]) + AW'(r_yd[i]);
        end
        n_p  = DW'(s_p  >>> F);
        n_qx = DW'(s_qx >>> F);
        n_qy = DW'(s_qy >>> F);
    end

    // Stage 2: register rounded dot products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p  <= n_p;
            o_qx <= n_qx;
            o_qy <= n_qy;
        end
    end

endmodule

### design/rdr_reflect_lane.sv
// Two-stage lane: dD - 2 (p dN + q n), rounded and saturated per component.
module rdr_reflect_lane
    import rdr_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [N_COMP*COMP_WIDTH-1:0]           i_dd,
    input  logic [N_COMP*COMP_WIDTH-1:0]           i_dn,
    input  logic [N_COMP*COMP_WIDTH-1:0]           i_nrm,
    input  logic signed [COMP_WIDTH+DOT_GROW-1:0]  i_p,
    input  logic signed [COMP_WIDTH+DOT_GROW-1:0]  i_q,
    output logic [N_COMP*COMP_WIDTH-1:0]           o_res
);

    localparam int W  = COMP_WIDTH;
    localparam int F  = COMP_WIDTH - INT_BITS;
    localparam int DW = W + DOT_GROW;
    localparam int MW = DW + W;
    localparam int SW = 2 * W + 10;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);
    localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINV = -(SW'(1) <<< (W - 1));

    logic signed [W-1:0]  dd  [N_COMP];
    logic signed [W-1:0]  dn  [N_COMP];
    logic signed [W-1:0]  nv  [N_COMP];

    logic signed [MW-1:0] r_pt   [N_COMP];
    logic signed [MW-1:0] r_qt   [N_COMP];
    logic signed [W-1:0]  r_base [N_COMP];

    logic signed [SW-1:0] acc    [N_COMP];
    logic signed [SW-1:0] rnd    [N_COMP];
    logic [N_COMP*W-1:0]  n_res;

    // Unpack components
    always_comb begin
        for (int i = 0; i < N_COMP; i++) begin
            dd[i] = $signed(i_dd[(N_COMP-1-i)*W +: W]);
            dn[i] = $signed(i_dn[(N_COMP-1-i)*W +: W]);
            nv[i] = $signed(i_nrm[(N_COMP-1-i)*W +: W]);
        end
    end

    // Stage A: register scaled products and the base component
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N_COMP; i++) begin
                r_pt[i]   <= i_p * dn[i];
                r_qt[i]   <= i_q * nv[i];
                r_base[i] <= dd[i];
            end
        end
    end

    // Combine, round half up, saturate to the component range
    always_comb begin
        n_res = '0;
        for (int i = 0; i < N_COMP; i++) begin
            acc[i] = (SW'(r_base[i]) <<< F) - ((SW'(r_pt[i]) + SW'(r_qt[i])) <<< 1);
            rnd[i] = (acc[i] + HALF) >>> F;
            if (rnd[i] > MAXV) begin
                n_res[(N_COMP-1-i)*W +: W] = MAXV[W-1:0];
            end else if (rnd[i] < MINV) begin
                n_res[(N_COMP-1-i)*W +: W] = MINV[W-1:0];
            end else begin
                n_res[(N_COMP-1-i)*W +: W] = rnd[i][W-1:0];
            end
        end
    end

    // Stage B: output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= n_res;
        end
    end

endmodule

### tb/ray_differential_reflect_test.sv
// Self-checking testbench for the ray differential reflection pipeline.
module ray_differential_reflect_test;
    import rdr_pkg::*;

    localparam int CW = COMP_WIDTH_DEF;
    localparam int FRAC = CW - INT_BITS;
    localparam int VW = N_COMP * CW;
    localparam int ONE = 1 << FRAC;
    localparam int MAXC = (1 << (CW - 1)) - 1;
    localparam int MINC = -(1 << (CW - 1));
    localparam int LATENCY = 4;
    localparam int N_RANDOM = 650;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int HOLDOFF_AT = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED = 40;

    typedef logic [VW-1:0] t_vec;

    typedef struct packed {
        t_vec dir;
        t_vec nrm;
        t_vec ndu;
        t_vec ndv;
        t_vec ddx;
        t_vec ddy;
    } t_ray_item;

    typedef struct packed {
        t_vec dir;
        t_vec dx;
        t_vec dy;
    } t_refl_set;

    // Expected reflections in order, plus the fixed-point predictor that makes them
    class reflection_board;
        t_refl_set pending_reflections[$];
        int mismatches = 0;
        int checked = 0;

        function longint comp(t_vec v, int i);
            logic signed [CW-1:0] c;
            c = v[(2 - i) * CW +: CW];
            return longint'(c);
        endfunction

        // Round half up to FRAC fraction bits (floor after adding half an lsb)
        function longint round_fix(longint x);
            return (x + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        endfunction

        function longint dot3(t_vec a, t_vec b);
            return comp(a, 0) * comp(b, 0) + comp(a, 1) * comp(b, 1) + comp(a, 2) * comp(b, 2);
        endfunction

        // dd - 2 (p dn + q n), rounded and saturated per component
        function t_vec reflect_vec(t_vec dd, t_vec dn, t_vec n, longint p, longint q);
            t_vec w;
            longint t;
            longint r;
            for (int i = 0; i < N_COMP; i++) begin
                t = p * comp(dn, i) + q * comp(n, i);
                r = round_fix(comp(dd, i) * (64'sd1 <<< FRAC) - 2 * t);
                if (r > MAXC) r = MAXC;
                if (r < MINC) r = MINC;
                w[(2 - i) * CW +: CW] = r[CW-1:0];
            end
            return w;
        endfunction

        function void note_ray(t_ray_item it);
            t_refl_set e;
            longint p;
            longint qx;
            longint qy;
            p = round_fix(dot3(it.dir, it.nrm));
            qx = round_fix(dot3(it.ddx, it.nrm) + dot3(it.dir, it.ndu));
            qy = round_fix(dot3(it.ddy, it.nrm) + dot3(it.dir, it.ndv));
            e.dir = reflect_vec(it.dir, '0, it.nrm, 0, p);
            e.dx = reflect_vec(it.ddx, it.ndu, it.nrm, p, qx);
            e.dy = reflect_vec(it.ddy, it.ndv, it.nrm, p, qy);
            pending_reflections.push_back(e);
        endfunction

        task report(string msg);
            if (mismatches < MAX_PRINTED)
                $display("ERROR at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_reflection(t_vec dir, t_vec dx, t_vec dy);
            t_refl_set e;
            if (pending_reflections.size() == 0) begin
                report($sformatf("result %0d with no transaction pending", checked));
            end else begin
                e = pending_reflections.pop_front();
                if (dir !== e.dir)
                    report($sformatf("result %0d refl_dir got %h want %h", checked, dir, e.dir));
                if (dx !== e.dx)
                    report($sformatf("result %0d refl_dir_dx got %h want %h", checked, dx, e.dx));
                if (dy !== e.dy)
                    report($sformatf("result %0d refl_dir_dy got %h want %h", checked, dy, e.dy));
            end
            checked++;
        endtask

        function int pending();
            return pending_reflections.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic o_valid;
    logic i_stall;
    t_vec i_ray_dir;
    t_vec i_surf_normal;
    t_vec i_normal_du;
    t_vec i_normal_dv;
    t_vec i_dir_dx;
    t_vec i_dir_dy;
    t_vec o_refl_dir;
    t_vec o_refl_dir_dx;
    t_vec o_refl_dir_dy;

    reflection_board board = new();
    int rays_accepted = 0;
    int idle_cycles = 0;
    int item_idx = 0;
    int burst_left = 0;
    bit holdoff_done = 0;

    ray_differential_reflect u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ray_dir     (i_ray_dir),
        .i_surf_normal (i_surf_normal),
        .i_normal_du   (i_normal_du),
        .i_normal_dv   (i_normal_dv),
        .i_dir_dx      (i_dir_dx),
        .i_dir_dy      (i_dir_dy),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_refl_dir    (o_refl_dir),
        .o_refl_dir_dx (o_refl_dir_dx),
        .o_refl_dir_dy (o_refl_dir_dy)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Predict every accepted input transaction
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            board.note_ray({i_ray_dir, i_surf_normal, i_normal_du, i_normal_dv,
                            i_dir_dx, i_dir_dy});
            rays_accepted++;
        end
    end

    // Check every accepted output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_reflection(o_refl_dir, o_refl_dir_dx, o_refl_dir_dy);
    end

    // Count cycles without any transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Receiver: stall on changing patterns, with one long hold-off under load
    initial begin
        int cyc;
        int mode;
        i_stall = 1'b0;
        cyc = 0;
        mode = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!holdoff_done && rays_accepted >= HOLDOFF_AT) begin
                holdoff_done = 1;
                i_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (cyc % 32 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 99) < 20);
                    2: i_stall <= ($urandom_range(0, 99) < 65);
                    default: i_stall <= (cyc % 3 == 0);
                endcase
                cyc++;
            end
        end
    end

    function automatic t_vec pack3(int x, int y, int z);
        return {x[CW-1:0], y[CW-1:0], z[CW-1:0]};
    endfunction

    // Draw one component: full range, unit scale, differential scale or an extreme
    function automatic logic [CW-1:0] rand_comp(int style);
        int v;
        case (style)
            0: v = int'($urandom);
            1: v = int'($urandom_range(0, 2 * ONE)) - ONE;
            2: v = int'($urandom_range(0, ONE / 8)) - ONE / 16;
            default: begin
                case ($urandom_range(0, 4))
                    0: v = MAXC;
                    1: v = MINC;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
        endcase
        return v[CW-1:0];
    endfunction

    function automatic t_vec rand_vec(int style);
        t_vec w;
        for (int i = 0; i < N_COMP; i++) begin
            if ($urandom_range(0, 19) == 0)
                w[i * CW +: CW] = rand_comp(3);
            else
                w[i * CW +: CW] = rand_comp(style);
        end
        return w;
    endfunction

    function automatic t_ray_item rand_ray();
        t_ray_item it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            // plausible geometry: unit-scale vectors, small differentials
            it.dir = rand_vec(1);
            it.nrm = rand_vec(1);
            it.ndu = rand_vec(2);
            it.ndv = rand_vec(2);
            it.ddx = rand_vec(2);
            it.ddy = rand_vec(2);
        end else if (pick < 85) begin
            it = {rand_vec(0), rand_vec(0), rand_vec(0), rand_vec(0), rand_vec(0), rand_vec(0)};
        end else begin
            it = {rand_vec($urandom_range(0, 3)), rand_vec($urandom_range(0, 3)),
                  rand_vec($urandom_range(0, 3)), rand_vec($urandom_range(0, 3)),
                  rand_vec($urandom_range(0, 3)), rand_vec($urandom_range(0, 3))};
        end
        return it;
    endfunction

    // Offer one transaction and hold it until accepted
    task drive_ray(t_ray_item it);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_ray_dir <= it.dir;
        i_surf_normal <= it.nrm;
        i_normal_du <= it.ndu;
        i_normal_dv <= it.ndv;
        i_dir_dx <= it.ddx;
        i_dir_dy <= it.ddy;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Insert a random gap between bursts; keep streaming around the hold-off
    task pace_sender();
        int gap;
        item_idx++;
        if (item_idx >= 100 && item_idx < 260)
            return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task send_ray(t_vec d, t_vec n, t_vec ndu, t_vec ndv, t_vec ddx, t_vec ddy);
        drive_ray({d, n, ndu, ndv, ddx, ddy});
        pace_sender();
    endtask

    initial begin
        t_vec vmax;
        t_vec vmin;
        t_vec alt;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ray_dir = '0;
        i_surf_normal = '0;
        i_normal_du = '0;
        i_normal_dv = '0;
        i_dir_dx = '0;
        i_dir_dy = '0;
        vmax = pack3(MAXC, MAXC, MAXC);
        vmin = pack3(MINC, MINC, MINC);
        alt = {(VW / 2){2'b10}};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: all zero, field extremes, all ones, alternating bits
        send_ray('0, '0, '0, '0, '0, '0);
        send_ray(vmax, vmax, vmax, vmax, vmax, vmax);
        send_ray(vmin, vmin, vmin, vmin, vmin, vmin);
        send_ray('1, '1, '1, '1, '1, '1);
        send_ray(alt, ~alt, alt, ~alt, alt, ~alt);
        // Head-on and grazing hits with unit normals
        send_ray(pack3(ONE, 0, 0), pack3(ONE, 0, 0), pack3(0, ONE / 8, 0),
                 pack3(0, 0, ONE / 8), pack3(0, ONE / 4, 0), pack3(0, 0, -ONE / 4));
        send_ray(pack3(0, 0, -ONE), pack3(0, 0, ONE), pack3(ONE / 2, 0, 0),
                 pack3(0, -ONE / 2, 0), pack3(ONE / 16, 0, 0), pack3(0, ONE / 16, 0));
        send_ray(pack3(ONE, 0, 0), pack3(0, ONE, 0), pack3(0, 0, ONE),
                 pack3(ONE, 0, 0), pack3(0, 0, 1), pack3(-1, 0, 0));
        // Dot product lands exactly on half an lsb, positive and negative
        send_ray(pack3(1, 0, 0), pack3(ONE / 2, 0, 0), pack3(1, 0, 0),
                 pack3(-1, 0, 0), pack3(1, 0, 0), pack3(-1, 0, 0));
        send_ray(pack3(-1, 0, 0), pack3(ONE / 2, 0, 0), pack3(-1, 0, 0),
                 pack3(1, 0, 0), pack3(-1, 0, 0), pack3(1, 0, 0));
        // Output component lands exactly on half an lsb
        send_ray(pack3(4, 0, 0), pack3(ONE / 4, 0, 0), pack3(0, 0, 0),
                 pack3(ONE / 4, 0, 0), pack3(4, 0, 0), pack3(-4, 0, 0));
        send_ray(pack3(-4, 0, 0), pack3(ONE / 4, 0, 0), pack3(ONE / 4, 0, 0),
                 pack3(0, 0, 0), pack3(-4, 0, 0), pack3(4, 0, 0));
        // Saturation high and low
        send_ray(vmax, vmin, vmax, vmin, vmax, vmin);
        send_ray(vmin, vmin, vmin, vmax, vmin, vmax);
        // Zero normal: direction and differentials pass through; then mixed extremes
        send_ray(vmax, '0, vmax, vmin, vmin, vmax);
        send_ray(pack3(MAXC, MINC, 0), pack3(MINC, MAXC, -1), pack3(1, -1, MAXC),
                 pack3(MINC, 0, 1), pack3(-1, MAXC, MINC), pack3(0, 1, -1));
        // Unit normal with oversized derivatives saturates only the differentials
        send_ray(pack3(ONE / 2, ONE / 2, 0), pack3(0, ONE, 0), vmax, vmin,
                 pack3(ONE, ONE, ONE), pack3(-ONE, -ONE, -ONE));
        // Unnormalized vectors of odd magnitude
        send_ray(pack3(3 * ONE, -5, 7), pack3(-2 * ONE, 3, ONE + 1), pack3(13, -17, 19),
                 pack3(-23, 29, -31), pack3(ONE / 3, -ONE / 5, ONE / 7),
                 pack3(-ONE / 3, ONE / 5, -ONE / 7));

        // Random traffic
        repeat (N_RANDOM) begin
            drive_ray(rand_ray());
            pace_sender();
        end

        // Drain
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4 * LATENCY) @(posedge i_clk);

        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
design/rdr_pkg.sv
design/rdr_dot_unit.sv
design/rdr_reflect_lane.sv
design/ray_differential_reflect.sv
tb/ray_differential_reflect_test.sv
